// ===== rtl/group_varint_encoder_unit_defines.svh =====
// ----------------------------------------------------------------------------
// group_varint_encoder_unit_defines.svh
// Assertion macros for the group varint encoder.
// ----------------------------------------------------------------------------
`ifndef GROUP_VARINT_ENCODER_UNIT_DEFINES_SVH
`define GROUP_VARINT_ENCODER_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
`define GVE_ASSERT_IMP(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("gve assertion failed");
`define GVE_ASSERT_NXT(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("gve assertion failed");
`else
`define GVE_ASSERT_IMP(name, clk, rst_n, ante, cons)
`define GVE_ASSERT_NXT(name, clk, rst_n, ante, cons)
`endif

`endif

// ===== rtl/gve_pkg.sv =====
// ----------------------------------------------------------------------------
// gve_pkg
// Types, constants and helpers shared by the group varint encoder.
// ----------------------------------------------------------------------------
package gve_pkg;

	localparam int BYTE_W  = 8;
	localparam int WIDE_W  = 64;
	localparam int SHORT_W = 32;

	localparam logic FMT_QUAD = 1'b0;
	localparam logic FMT_WIDE = 1'b1;

	typedef enum logic [2:0] {
		PH_HDR,
		PH_A,
		PH_B,
		PH_C,
		PH_D
	} phase_t;

	typedef struct packed {
		logic                 fmt;
		logic [WIDE_W-1:0]    a;
		logic [WIDE_W-1:0]    b;
		logic [SHORT_W-1:0]   c;
		logic [SHORT_W-1:0]   d;
		logic [2:0]           la_m1;
		logic [2:0]           lb_m1;
		logic [1:0]           lc_m1;
		logic [1:0]           ld_m1;
		logic [BYTE_W-1:0]    hdr;
	} entry_t;

	typedef struct packed {
		logic empty;
		logic full;
	} q_status_t;

	// index of the highest nonzero byte, zero for a zero value
	function automatic logic [2:0] top_byte64(input logic [WIDE_W-1:0] v);
		logic [2:0] n;
		n = '0;
		for (int i = 1; i < 8; i++) begin
			if (v[BYTE_W*i +: BYTE_W] != '0) n = 3'(i);
		end
		return n;
	endfunction

	function automatic logic [1:0] top_byte32(input logic [SHORT_W-1:0] v);
		logic [1:0] n;
		n = '0;
		for (int i = 1; i < 4; i++) begin
			if (v[BYTE_W*i +: BYTE_W] != '0) n = 2'(i);
		end
		return n;
	endfunction

endpackage

// ===== rtl/gve_in_if.sv =====
// ----------------------------------------------------------------------------
// gve_in_if
// Input channel: one group of values per request.
// ----------------------------------------------------------------------------
interface gve_in_if;
	logic        valid;
	logic        ready;
	logic [63:0] value_a;
	logic [63:0] value_b;
	logic [31:0] value_c;
	logic [31:0] value_d;

	modport source (output valid, value_a, value_b, value_c, value_d, input ready);
	modport sink (input valid, value_a, value_b, value_c, value_d, output ready);
endinterface

// ===== rtl/gve_out_if.sv =====
// ----------------------------------------------------------------------------
// gve_out_if
// Output channel: one encoded byte per request.
// ----------------------------------------------------------------------------
interface gve_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       last_byte;

	modport source (output valid, out_byte, last_byte, input ready);
	modport sink (input valid, out_byte, last_byte, output ready);
endinterface

// ===== rtl/gve_front.sv =====
// ----------------------------------------------------------------------------
// gve_front
// Accepts a group, sizes each value and builds the header byte.
// ----------------------------------------------------------------------------
module gve_front (
	input  logic             group_format,
	gve_in_if.sink           in_ch,
	input  gve_pkg::q_status_t q_status,
	output logic             push,
	output gve_pkg::entry_t  push_entry
);
	import gve_pkg::*;

	logic [WIDE_W-1:0] a_eff;
	logic [WIDE_W-1:0] b_eff;
	logic [2:0]        la_m1;
	logic [2:0]        lb_m1;
	logic [1:0]        lc_m1;
	logic [1:0]        ld_m1;

	assign in_ch.ready = !q_status.full;
	assign push        = in_ch.valid && !q_status.full;

	assign a_eff = (group_format == FMT_WIDE) ? in_ch.value_a
	                                          : {32'd0, in_ch.value_a[SHORT_W-1:0]};
	assign b_eff = (group_format == FMT_WIDE) ? in_ch.value_b
	                                          : {32'd0, in_ch.value_b[SHORT_W-1:0]};

	always_comb begin
		la_m1 = top_byte64(a_eff);
		lb_m1 = top_byte64(b_eff);
		lc_m1 = top_byte32(in_ch.value_c);
		ld_m1 = top_byte32(in_ch.value_d);
	end

	always_comb begin
		push_entry.fmt   = group_format;
		push_entry.a     = a_eff;
		push_entry.b     = b_eff;
		push_entry.c     = in_ch.value_c;
		push_entry.d     = in_ch.value_d;
		push_entry.la_m1 = la_m1;
		push_entry.lb_m1 = lb_m1;
		push_entry.lc_m1 = lc_m1;
		push_entry.ld_m1 = ld_m1;
		if (group_format == FMT_WIDE) begin
			push_entry.hdr = {la_m1, lb_m1, lc_m1};
		end else begin
			push_entry.hdr = {la_m1[1:0], lb_m1[1:0], lc_m1, ld_m1};
		end
	end

endmodule

// ===== rtl/gve_queue.sv =====
// ----------------------------------------------------------------------------
// gve_queue
// Short FIFO of sized groups between front and back.
// ----------------------------------------------------------------------------
`include "group_varint_encoder_unit_defines.svh"

module gve_queue #(
	parameter int DEPTH = 2
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  gve_pkg::entry_t     push_entry,
	input  logic                pop,
	output gve_pkg::entry_t     pop_entry,
	output gve_pkg::q_status_t  status
);
	import gve_pkg::*;

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	entry_t             mem_q [DEPTH];
	logic [PTR_W-1:0]   wptr_q;
	logic [PTR_W-1:0]   rptr_q;
	logic [CNT_W-1:0]   count_q;

	assign status.empty = (count_q == '0);
	assign status.full  = (count_q == CNT_W'(DEPTH));
	assign pop_entry    = mem_q[rptr_q];

	always_ff @(posedge clk) begin
		if (push) mem_q[wptr_q] <= push_entry;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wptr_q <= (wptr_q == PTR_W'(DEPTH - 1)) ? '0 : wptr_q + 1'b1;
			end
			if (pop) begin
				rptr_q <= (rptr_q == PTR_W'(DEPTH - 1)) ? '0 : rptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	`GVE_ASSERT_IMP(a_no_push_full, clk, arst_n, push, count_q != CNT_W'(DEPTH))
	`GVE_ASSERT_IMP(a_no_pop_empty, clk, arst_n, pop, count_q != '0)
	`GVE_ASSERT_NXT(a_ptr_track, clk, arst_n, push && !pop && count_q == '0, count_q == CNT_W'(1) && rptr_q != wptr_q || DEPTH == 1)

endmodule

// ===== rtl/gve_back.sv =====
// ----------------------------------------------------------------------------
// gve_back
// Walks a sized group and emits header and value bytes, one per cycle unless out_ch stalls.
// ----------------------------------------------------------------------------
`include "group_varint_encoder_unit_defines.svh"

module gve_back (
	input  logic               clk,
	input  logic               arst_n,
	input  gve_pkg::q_status_t q_status,
	input  gve_pkg::entry_t    q_entry,
	output logic               pop,
	gve_out_if.source          out_ch
);
	import gve_pkg::*;

	entry_t             entry_q;
	logic               busy_q;
	phase_t             phase_q;
	logic [2:0]         idx_q;
	logic               out_valid_q;
	logic [BYTE_W-1:0]  out_byte_q;
	logic               last_q;

	phase_t             phase_d;
	logic [2:0]         idx_d;
	logic               busy_d;
	logic               emit;
	logic               done;
	logic               load;
	logic [BYTE_W-1:0]  cur_byte;
	logic               last_now;

	assign emit = busy_q && (!out_valid_q || out_ch.ready);
	assign done = emit && last_now;
	assign load = !q_status.empty && (!busy_q || done);
	assign pop  = load;

	// byte select and end-of-group detect
	always_comb begin
		cur_byte = entry_q.hdr;
		last_now = 1'b0;
		case (phase_q)
			PH_HDR: begin
				cur_byte = entry_q.hdr;
			end
			PH_A: begin
				cur_byte = entry_q.a[BYTE_W*idx_q +: BYTE_W];
			end
			PH_B: begin
				cur_byte = entry_q.b[BYTE_W*idx_q +: BYTE_W];
			end
			PH_C: begin
				cur_byte = entry_q.c[BYTE_W*idx_q[1:0] +: BYTE_W];
				last_now = (entry_q.fmt == FMT_WIDE) && (idx_q[1:0] == entry_q.lc_m1);
			end
			PH_D: begin
				cur_byte = entry_q.d[BYTE_W*idx_q[1:0] +: BYTE_W];
				last_now = (idx_q[1:0] == entry_q.ld_m1);
			end
			default: begin
				cur_byte = entry_q.hdr;
			end
		endcase
	end

	// sequencer next state
	always_comb begin
		phase_d = phase_q;
		idx_d   = idx_q;
		busy_d  = busy_q;
		if (emit) begin
			idx_d = idx_q + 1'b1;
			case (phase_q)
				PH_HDR: begin
					phase_d = PH_A;
					idx_d   = '0;
				end
				PH_A: begin
					if (idx_q == entry_q.la_m1) begin
						phase_d = PH_B;
						idx_d   = '0;
					end
				end
				PH_B: begin
					if (idx_q == entry_q.lb_m1) begin
						phase_d = PH_C;
						idx_d   = '0;
					end
				end
				PH_C: begin
					if (idx_q[1:0] == entry_q.lc_m1) begin
						phase_d = PH_D;
						idx_d   = '0;
					end
				end
				PH_D: begin
					idx_d = idx_q + 1'b1;
				end
				default: begin
					phase_d = PH_HDR;
					idx_d   = '0;
				end
			endcase
		end
		if (done) busy_d = 1'b0;
		if (load) begin
			busy_d  = 1'b1;
			phase_d = PH_HDR;
			idx_d   = '0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) entry_q <= q_entry;
		if (emit) begin
			out_byte_q <= cur_byte;
			last_q     <= last_now;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			phase_q     <= PH_HDR;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			busy_q  <= busy_d;
			phase_q <= phase_d;
			idx_q   <= idx_d;
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_ch.valid     = out_valid_q;
	assign out_ch.out_byte  = out_byte_q;
	assign out_ch.last_byte = last_q;

	`GVE_ASSERT_NXT(a_last_ends_group, clk, arst_n, done, !busy_q || phase_q == PH_HDR)
	`GVE_ASSERT_IMP(a_no_d_wide, clk, arst_n, busy_q && phase_q == PH_D, entry_q.fmt == FMT_QUAD)
	`GVE_ASSERT_IMP(a_c_idx_range, clk, arst_n, busy_q && phase_q == PH_C, idx_q <= {1'b0, entry_q.lc_m1})

endmodule

// ===== rtl/group_varint_encoder_unit.sv =====
// ----------------------------------------------------------------------------
// group_varint_encoder_unit
// Group varint encoder: one group of integers in, a header byte and the
// minimal little-endian bytes of each value out.
// ----------------------------------------------------------------------------
// Output runs at one byte per cycle while out_ch is ready, and a group is
// 1 + (sum of value byte counts) bytes: 5 to 17 in the four-value format,
// 4 to 21 in the wide format. The single byte-wide output sequencer sets this
// rate. A group is sized and queued on the cycle it is accepted; input is
// taken whenever the group queue (QUEUE_DEPTH entries) has room, and the back
// end loads the next group as the previous last byte is emitted, then sends
// its header. Write group_format only while the unit is idle.
module group_varint_encoder_unit #(
	parameter int QUEUE_DEPTH = 2
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      cfg_we,
	input  logic      cfg_wdata,
	gve_in_if.sink    in_ch,
	gve_out_if.source out_ch
);
	import gve_pkg::*;

	logic      group_format_q;
	logic      push;
	logic      pop;
	entry_t    push_entry;
	entry_t    pop_entry;
	q_status_t q_status;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			group_format_q <= FMT_QUAD;
		end else if (cfg_we) begin
			group_format_q <= cfg_wdata;
		end
	end

	gve_front u_front (
		.group_format (group_format_q),
		.in_ch        (in_ch),
		.q_status     (q_status),
		.push         (push),
		.push_entry   (push_entry)
	);

	gve_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.pop        (pop),
		.pop_entry  (pop_entry),
		.status     (q_status)
	);

	gve_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_status (q_status),
		.q_entry  (pop_entry),
		.pop      (pop),
		.out_ch   (out_ch)
	);

endmodule
